[hdl/assert_macros.svh]
// Assertion macros shared by the checker files of the pose integrator.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define UPI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define UPI_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[hdl/upi_pkg.sv]
// Package for the unicycle pose integrator: word types, register indexes,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
`default_nettype none

package upi_pkg;

    typedef struct packed {
        logic signed [15:0] linear_velocity;
        logic signed [15:0] angular_velocity;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } out_word_t;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_TIME = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_X   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Y   = 2'd2;

    localparam logic [15:0]        STEP_TIME_RST = 16'd1966;
    localparam logic signed [31:0] START_X_RST   = -32'sd65536;
    localparam logic signed [31:0] START_Y_RST   = -32'sd131072;

    // Operand width of the serial multipliers and of the CORDIC x/y datapath.
    localparam int MUL_W  = 34;
    localparam int ROT_W  = 34;
    localparam int ANG_W  = 33;

    // 2^31/pi, rounded: radians in Q4.12 times seconds to binary angle.
    localparam logic signed [MUL_W-1:0] RAD_TO_BAM = 34'sd683565276;
    // CORDIC start vector, the inverse gain in Q2.30.
    localparam logic signed [ROT_W-1:0] CORDIC_X0  = 34'sd652032874;

    localparam int TABLE_LEN = 24;
    localparam int ITER_W    = $clog2(TABLE_LEN);

    // atan(2^-i) in units where 2^31 equals pi.
    function automatic logic [29:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [29:0] val;
        unique case (idx)
            5'd0:    val = 30'h20000000;
            5'd1:    val = 30'h12E4051E;
            5'd2:    val = 30'h09FB385B;
            5'd3:    val = 30'h051111D4;
            5'd4:    val = 30'h028B0D43;
            5'd5:    val = 30'h0145D7E1;
            5'd6:    val = 30'h00A2F61E;
            5'd7:    val = 30'h00517C55;
            5'd8:    val = 30'h0028BE53;
            5'd9:    val = 30'h00145F2F;
            5'd10:   val = 30'h000A2F98;
            5'd11:   val = 30'h000517CC;
            5'd12:   val = 30'h00028BE6;
            5'd13:   val = 30'h000145F3;
            5'd14:   val = 30'h0000A2FA;
            5'd15:   val = 30'h0000517D;
            5'd16:   val = 30'h000028BE;
            5'd17:   val = 30'h0000145F;
            5'd18:   val = 30'h00000A30;
            5'd19:   val = 30'h00000518;
            5'd20:   val = 30'h0000028C;
            5'd21:   val = 30'h00000146;
            5'd22:   val = 30'h000000A3;
            5'd23:   val = 30'h00000051;
            default: val = 30'h0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[hdl/upi_serial_mul.sv]
// Bit-serial signed multiplier: the multiplier operand shifts out one bit per
// cycle, LSB first, into a narrow accumulator. Uses no package.
`default_nettype none

module upi_serial_mul #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [AW-1:0] a_in,
    input  logic signed [BW-1:0] b_in,
    output logic                 busy,
    output logic [AW+BW-1:0]     product
);

    localparam int CNT_W = $clog2(BW);

    logic signed [AW-1:0] a_reg;
    logic [AW:0]          acc_reg;
    logic [BW-1:0]        lo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;

    logic                 last_bit;
    logic [AW+1:0]        a_ext;
    logic [AW+1:0]        addend;
    logic [AW+1:0]        sum;

    assign last_bit = (cnt_reg == CNT_W'(BW - 1));
    assign a_ext    = {{2{a_reg[AW-1]}}, a_reg};

    // The sign bit of the multiplier carries negative weight, so it subtracts.
    always_comb begin
        if (lo_reg[0]) begin
            addend = last_bit ? (~a_ext + 1'b1) : a_ext;
        end else begin
            addend = '0;
        end
        sum = {acc_reg[AW], acc_reg} + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last_bit) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_in;
            acc_reg <= '0;
            lo_reg  <= b_in;
        end else if (busy_reg) begin
            acc_reg <= sum[AW+1:1];
            lo_reg  <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = {acc_reg[AW-1:0], lo_reg};

endmodule

`default_nettype wire

[hdl/upi_cordic.sv]
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle,
// one micro-rotation per cycle. Depends on upi_pkg.
`default_nettype none

module upi_cordic #(
    parameter int STEPS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [15:0]            angle,
    output logic                          busy,
    output logic signed [upi_pkg::ROT_W-1:0] cos_out,
    output logic signed [upi_pkg::ROT_W-1:0] sin_out
);

    import upi_pkg::*;

    localparam int N_ITER = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

    logic signed [ROT_W-1:0] x_reg;
    logic signed [ROT_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic                    flip_reg;
    logic                    busy_reg;

    logic signed [16:0]      a_ext;
    logic signed [16:0]      a_fold;
    logic                    fold;
    logic signed [ROT_W-1:0] x_sh;
    logic signed [ROT_W-1:0] y_sh;
    logic signed [ANG_W-1:0] atan_val;

    // Angles beyond a quarter turn are rotated by half a turn first and the
    // results negated at the end.
    always_comb begin
        a_ext = {angle[15], angle};
        fold  = 1'b0;
        if (a_ext > 17'sd16384) begin
            a_fold = a_ext - 17'sd32768;
            fold   = 1'b1;
        end else if (a_ext < -17'sd16384) begin
            a_fold = a_ext + 17'sd32768;
            fold   = 1'b1;
        end else begin
            a_fold = a_ext;
        end
    end

    assign x_sh     = x_reg >>> iter_reg;
    assign y_sh     = y_reg >>> iter_reg;
    assign atan_val = $signed({3'b000, atan_entry(iter_reg)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == ITER_W'(N_ITER - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= {a_fold[15], a_fold[15:0], 16'h0000};
            flip_reg <= fold;
        end else if (busy_reg) begin
            if (!z_reg[ANG_W-1]) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_val;
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_val;
            end
        end
    end

    assign busy    = busy_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

`default_nettype wire

[hdl/unicycle_pose_integrator_core.sv]
// Dead-reckoning pose integrator for a unicycle robot. Each velocity word turns
// the heading by step_time * angular_velocity (16-bit binary angle, wrapping),
// then moves x and y by linear_velocity * cos/sin(heading) * step_time with
// saturation, and returns one word with the new pose. The two products that
// dominate go through bit-serial multipliers that retire one multiplier bit per
// cycle, and the CORDIC does one micro-rotation per cycle. One word is in work
// at a time; the result register frees the input side as soon as the result is
// loaded, so the next word can be taken in the same cycle as the result appears.
// Writing start_x or start_y also moves the pose to that coordinate, unless a
// result is committed in that cycle, when the write is lost.
// Depends on upi_pkg, upi_serial_mul and upi_cordic.
`default_nettype none

module unicycle_pose_integrator_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  upi_pkg::in_word_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output upi_pkg::out_word_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [upi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [upi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import upi_pkg::*;

    localparam logic [2:0] ST_BOOT     = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_HEAD     = 3'd2;
    localparam logic [2:0] ST_ROT_LOAD = 3'd3;
    localparam logic [2:0] ST_ROT      = 3'd4;
    localparam logic [2:0] ST_MOVE     = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [15:0]        step_time_reg;
    logic [31:0]        x_pos_reg;
    logic [31:0]        y_pos_reg;
    logic [15:0]        heading_reg;
    logic signed [32:0] vdt_reg;
    out_word_t          out_reg;
    logic               m_valid_reg;

    logic               accept;
    logic               out_free;
    logic               commit;
    logic signed [32:0] turn_prod;
    logic signed [32:0] move_prod;

    logic                          mul_x_start;
    logic                          mul_y_start;
    logic signed [MUL_W-1:0]       mul_x_a;
    logic signed [MUL_W-1:0]       mul_x_b;
    logic                          mul_x_busy;
    logic                          mul_y_busy;
    logic [2*MUL_W-1:0]            prod_x;
    logic [2*MUL_W-1:0]            prod_y;

    logic                          rot_start;
    logic                          rot_busy;
    logic signed [ROT_W-1:0]       cos_val;
    logic signed [ROT_W-1:0]       sin_val;

    logic [33:0]        sum_x;
    logic [33:0]        sum_y;
    logic [31:0]        new_x;
    logic [31:0]        new_y;

    function automatic logic [31:0] sat32(input logic [33:0] v);
        logic [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (!v[33]) begin
            r = 32'h7FFF_FFFF;
        end else begin
            r = 32'h8000_0000;
        end
        return r;
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_MOVE) && !mul_x_busy && !mul_y_busy && out_free;

    assign turn_prod = $signed({1'b0, step_time_reg}) * s_data.angular_velocity;
    assign move_prod = $signed({1'b0, step_time_reg}) * s_data.linear_velocity;

    // The x multiplier first forms the heading increment, then the x step.
    assign mul_x_start = accept || ((state_reg == ST_ROT) && !rot_busy);
    assign mul_y_start = (state_reg == ST_ROT) && !rot_busy;
    assign mul_x_a     = (state_reg == ST_IDLE) ? {turn_prod[32], turn_prod}
                                                : {vdt_reg[32], vdt_reg};
    assign mul_x_b     = (state_reg == ST_IDLE) ? RAD_TO_BAM : cos_val;
    assign rot_start   = (state_reg == ST_ROT_LOAD);

    upi_serial_mul #(
        .AW (MUL_W),
        .BW (MUL_W)
    ) u_mul_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_x_start),
        .a_in    (mul_x_a),
        .b_in    (mul_x_b),
        .busy    (mul_x_busy),
        .product (prod_x)
    );

    upi_serial_mul #(
        .AW (MUL_W),
        .BW (MUL_W)
    ) u_mul_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_y_start),
        .a_in    ({vdt_reg[32], vdt_reg}),
        .b_in    (sin_val),
        .busy    (mul_y_busy),
        .product (prod_y)
    );

    upi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rot_start),
        .angle   (heading_reg),
        .busy    (rot_busy),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    // Rounding half up before dropping 42 fraction bits is the same as adding
    // the highest dropped bit to the kept part.
    assign sum_x = {{2{x_pos_reg[31]}}, x_pos_reg} + {{8{prod_x[67]}}, prod_x[67:42]}
                   + {33'b0, prod_x[41]};
    assign sum_y = {{2{y_pos_reg[31]}}, y_pos_reg} + {{8{prod_y[67]}}, prod_y[67:42]}
                   + {33'b0, prod_y[41]};
    assign new_x = sat32(sum_x);
    assign new_y = sat32(sum_y);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_BOOT:     state_next = ST_IDLE;
            ST_IDLE:     if (accept) state_next = ST_HEAD;
            ST_HEAD:     if (!mul_x_busy) state_next = ST_ROT_LOAD;
            ST_ROT_LOAD: state_next = ST_ROT;
            ST_ROT:      if (!rot_busy) state_next = ST_MOVE;
            ST_MOVE:     if (commit) state_next = ST_IDLE;
            default:     state_next = ST_BOOT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_BOOT;
            m_valid_reg   <= 1'b0;
            step_time_reg <= STEP_TIME_RST;
            x_pos_reg     <= START_X_RST;
            y_pos_reg     <= START_Y_RST;
            heading_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_HEAD) && !mul_x_busy) begin
                heading_reg <= heading_reg + prod_x[59:44] + {15'b0, prod_x[43]};
            end
            if (commit) begin
                x_pos_reg <= new_x;
                y_pos_reg <= new_y;
            end else if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_STEP_TIME: step_time_reg <= cfg_wdata[15:0];
                    REG_START_X:   x_pos_reg     <= cfg_wdata;
                    REG_START_Y:   y_pos_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            vdt_reg <= move_prod;
        end
        if (commit) begin
            out_reg.pos_x   <= new_x;
            out_reg.pos_y   <= new_y;
            out_reg.heading <= heading_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

[hdl/upi_checker.sv]
// Port-level checker for the pose integrator top level, attached by bind.
// Depends on upi_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module upi_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input upi_pkg::out_word_t  m_data
);

    // The block does not take another word straight after it has accepted one.
    `UPI_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready ##1 !s_ready, "input taken again too soon after a word was accepted")

    // A new result appears only as the block returns to idle.
    `UPI_ASSERT_NEVER(a_result_when_idle, aclk, aresetn, $rose(m_valid) && !s_ready, "result word appeared while a word is still in work")

    `UPI_ASSERT(a_result_held, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "stalled result word dropped or changed")

endmodule

bind unicycle_pose_integrator_core upi_checker u_upi_checker (.*);

`default_nettype wire

[dv/unicycle_pose_integrator_core_test.sv]
// Self-checking testbench for unicycle_pose_integrator_core: directed and random velocity
// words checked against a fixed-point dead-reckoning predictor kept in the bench.
// Depends on upi_pkg and the core with its submodules.

module unicycle_pose_integrator_core_test;

    import upi_pkg::*;

    localparam int STEPS = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int END_PAUSE = 120;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;
    localparam longint BAM_PER_RAD = 683565276;
    localparam longint GAIN_X0 = 652032874;
    localparam longint INT32_TOP = 2147483647;
    localparam longint INT32_BOTTOM = -64'sd2147483648;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predicted state of the block and its registers.
    logic [15:0] step_dt;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;

    out_word_t pending_poses[$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;

    unicycle_pose_integrator_core #(
        .CORDIC_STEPS(STEPS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // atan(2^-i) where 2^31 stands for pi.
    function automatic longint arctan_step(input int idx);
        longint val;
        case (idx)
            0: val = 'h20000000;
            1: val = 'h12E4051E;
            2: val = 'h09FB385B;
            3: val = 'h051111D4;
            4: val = 'h028B0D43;
            5: val = 'h0145D7E1;
            6: val = 'h00A2F61E;
            7: val = 'h00517C55;
            8: val = 'h0028BE53;
            9: val = 'h00145F2F;
            10: val = 'h000A2F98;
            11: val = 'h000517CC;
            12: val = 'h00028BE6;
            13: val = 'h000145F3;
            14: val = 'h0000A2FA;
            15: val = 'h0000517D;
            16: val = 'h000028BE;
            17: val = 'h0000145F;
            18: val = 'h00000A30;
            19: val = 'h00000518;
            20: val = 'h0000028C;
            21: val = 'h00000146;
            22: val = 'h000000A3;
            23: val = 'h00000051;
            default: val = 0;
        endcase
        return val;
    endfunction

    // Rotation-mode CORDIC in Q2.30. Headings past +-pi/2 are folded by pi and the
    // outputs negated, so a heading of -pi gives a cosine of -1.
    function automatic void sin_cos(input logic signed [15:0] ang, output longint c,
                                    output longint s);
        longint a, x, y, z, xs, ys;
        int n, i;
        bit flip;
        a = ang;
        flip = 1'b0;
        if (a > 16384) begin
            a -= 32768;
            flip = 1'b1;
        end else if (a < -16384) begin
            a += 32768;
            flip = 1'b1;
        end
        x = GAIN_X0;
        y = 0;
        z = a * 65536;
        n = (STEPS > 24) ? 24 : STEPS;
        for (i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z -= arctan_step(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z += arctan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > INT32_TOP) return 32'sh7FFFFFFF;
        if (v < INT32_BOTTOM) return 32'sh80000000;
        return 32'(v);
    endfunction

    // Advances the predicted pose by one velocity word and returns the new pose.
    function automatic out_word_t predict_pose(input in_word_t cmd);
        longint v, w, dt, d, cs, sn, dx, dy;
        out_word_t r;
        v = cmd.linear_velocity;
        w = cmd.angular_velocity;
        dt = step_dt;
        d = (dt * w * BAM_PER_RAD + (longint'(1) << 43)) >>> 44;
        pose_heading = pose_heading + 16'(d);
        sin_cos(pose_heading, cs, sn);
        dx = (v * cs * dt + (longint'(1) << 41)) >>> 42;
        dy = (v * sn * dt + (longint'(1) << 41)) >>> 42;
        pose_x = clamp32(longint'(pose_x) + dx);
        pose_y = clamp32(longint'(pose_y) + dy);
        r.pos_x = pose_x;
        r.pos_y = pose_y;
        r.heading = pose_heading;
        return r;
    endfunction

    function automatic in_word_t make_cmd(input logic [15:0] v, input logic [15:0] w);
        in_word_t c;
        c.linear_velocity = v;
        c.angular_velocity = w;
        return c;
    endfunction

    function automatic in_word_t random_cmd();
        in_word_t c;
        int tmp;
        if ($urandom_range(9) < 7) begin
            c = in_word_t'($urandom);
        end else begin
            tmp = int'($urandom_range(8191)) - 4096;
            c.linear_velocity = 16'(tmp);
            tmp = int'($urandom_range(8191)) - 4096;
            c.angular_velocity = 16'(tmp);
        end
        return c;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Sends one velocity word; valid stays high afterwards until the next word or
    // until drain_pipeline lowers it.
    task automatic send_cmd(input in_word_t cmd);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= cmd;
        do @(posedge aclk); while (!s_ready);
        pending_poses.push_back(predict_pose(cmd));
    endtask

    // Stops sending and waits until every pending pose has come back.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge aclk);
    endtask

    // Only called while the block is idle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_STEP_TIME: step_dt = val[15:0];
            REG_START_X: pose_x = val;
            REG_START_Y: pose_y = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // With heading zero and a step of 2^-1 s, this turn rate lands exactly on -pi.
    task automatic test_half_turn();
        write_reg(REG_STEP_TIME, 32'd32768);
        send_cmd(make_cmd(16'sd4096, 16'sd25736));
        send_cmd(make_cmd(16'sd4096, 16'sd0));
        send_cmd(make_cmd(-16'sd4096, -16'sd25736));
        drain_pipeline();
    endtask

    task automatic test_velocity_extremes();
        write_reg(REG_STEP_TIME, 32'd65535);
        send_cmd(make_cmd(16'h7FFF, 16'h7FFF));
        send_cmd(make_cmd(16'h8000, 16'h8000));
        send_cmd(make_cmd(16'h7FFF, 16'h8000));
        send_cmd(make_cmd(16'h8000, 16'h7FFF));
        send_cmd(make_cmd(16'h0000, 16'h0001));
        send_cmd(make_cmd(16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(16'h0001, 16'h0000));
        drain_pipeline();
    endtask

    task automatic test_zero_step();
        write_reg(REG_STEP_TIME, 32'd0);
        send_cmd(make_cmd(16'h7FFF, 16'h7FFF));
        send_cmd(make_cmd(16'h8000, 16'h8000));
        drain_pipeline();
    endtask

    task automatic test_unmapped_register();
        write_reg(REG_STEP_TIME, 32'd1);
        write_reg(REG_UNMAPPED, 32'h8000FFFF);
        send_cmd(make_cmd(16'sd4096, 16'sd4096));
        drain_pipeline();
    endtask

    task automatic test_position_rails();
        write_reg(REG_STEP_TIME, 32'd65535);
        write_reg(REG_START_X, 32'h7FFFFFFF);
        write_reg(REG_START_Y, 32'h7FFFFFFF);
        repeat (3) send_cmd(make_cmd(16'h7FFF, 16'sd8192));
        repeat (3) send_cmd(make_cmd(16'h8000, 16'sd8192));
        drain_pipeline();
        write_reg(REG_START_X, 32'h80000000);
        write_reg(REG_START_Y, 32'h80000000);
        send_cmd(make_cmd(16'h7FFF, 16'h0000));
        send_cmd(make_cmd(16'h8000, 16'h0000));
        drain_pipeline();
    endtask

    task automatic test_random_drive(input int n_items, input int snd_pct, input int rcv_pct);
        int i;
        logic [31:0] val;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (i = 0; i < n_items; i++) begin
            if (i % 45 == 0) begin
                drain_pipeline();
                case ($urandom_range(5))
                    0: val = 32'd1;
                    1: val = 32'd65535;
                    2: val = 32'(STEP_TIME_RST);
                    default: val = $urandom_range(65535, 1);
                endcase
                write_reg(REG_STEP_TIME, val);
                if ($urandom_range(2) != 0) begin
                    case ($urandom_range(4))
                        0: val = 32'h7FFFFFFF;
                        1: val = 32'h80000000;
                        2: val = 32'h0;
                        default: val = $urandom;
                    endcase
                    write_reg(REG_START_X, val);
                    write_reg(REG_START_Y, $urandom);
                end
            end
            send_cmd(random_cmd());
        end
        drain_pipeline();
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_poses.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual x=%0d y=%0d heading=%0d",
                         $time, m_data.pos_x, m_data.pos_y, m_data.heading);
                mismatch_count++;
            end else begin
                want = pending_poses.pop_front();
                compare_field("pos_x", want.pos_x, m_data.pos_x);
                compare_field("pos_y", want.pos_y, m_data.pos_y);
                compare_field("heading", want.heading, m_data.heading);
            end
        end
    end

    // Ends the run when no word has moved on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        step_dt = STEP_TIME_RST;
        pose_x = START_X_RST;
        pose_y = START_Y_RST;
        pose_heading = '0;
        send_idle_pct = 8;
        recv_idle_pct = 66;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_half_turn();
        test_velocity_extremes();
        test_zero_step();
        test_unmapped_register();
        test_position_rails();
        test_random_drive(184, 8, 66);
        test_random_drive(183, 66, 8);
        test_random_drive(183, 0, 0);

        drain_pipeline();
        repeat (END_PAUSE) @(posedge aclk);
        if (mismatch_count == 0 && pending_poses.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
